// ===== sv/rdq_pkg.sv =====
// package for the reversible deque queue unit
// request, response and controller command types, operation codes, state codes
// no dependencies
package rdq_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int COUNT_FIELD_W = 5;

   typedef enum logic [1:0] {
      OP_INSERT_FRONT = 2'd0,
      OP_INSERT_BACK  = 2'd1,
      OP_REMOVE_FRONT = 2'd2,
      OP_REVERSE      = 2'd3
   } op_type;

   typedef struct packed {
      op_type             operation;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic                     ok;
      logic signed [31:0]       removed_value;
      logic [COUNT_FIELD_W-1:0] count;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic exec;
      logic respond;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE    = 3'b001,
      ST_EXEC    = 3'b010,
      ST_RESPOND = 3'b100
   } state_type;

endpackage

// ===== sv/rdq_controller.sv =====
// controller state machine of the reversible deque queue unit
// sequences accept, execute and respond; depends on rdq_pkg
module rdq_controller (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   output rdq_pkg::cmd_type cmd
);
   import rdq_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_EXEC;
         end
         ST_EXEC:    state_in = ST_RESPOND;
         ST_RESPOND: state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy        = (state_ff != ST_IDLE);
   assign cmd.load    = (state_ff == ST_IDLE) && start;
   assign cmd.exec    = (state_ff == ST_EXEC);
   assign cmd.respond = (state_ff == ST_RESPOND);

endmodule

// ===== sv/rdq_datapath.sv =====
// datapath of the reversible deque queue unit
// ring memory, front and back pointers, count and direction flag; depends on rdq_pkg
module rdq_datapath #(
   parameter int DEPTH = rdq_pkg::DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  rdq_pkg::cmd_type cmd,
   input  rdq_pkg::req_type req_payload,
   output rdq_pkg::rsp_type rsp_payload
);
   import rdq_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   logic signed [31:0] mem [DEPTH];

   req_type            req_ff;
   logic [PTR_W-1:0]   front_ff, front_in;
   logic [PTR_W-1:0]   back_ff, back_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               rev_ff, rev_in;
   logic               ok_ff, ok_in;
   logic               take_ff, take_in;
   logic signed [31:0] rd_ff;

   logic               wr_en, rd_en;
   logic [PTR_W-1:0]   wr_addr, rd_addr;
   logic [PTR_W-1:0]   front_dec, front_inc, back_dec, back_inc;
   logic               full, empty, go_low;
   logic [CNT_W+COUNT_FIELD_W-1:0] count_ext;

   assign front_dec = (front_ff == '0) ? PTR_LAST : front_ff - PTR_W'(1);
   assign front_inc = (front_ff == PTR_LAST) ? '0 : front_ff + PTR_W'(1);
   assign back_dec  = (back_ff == '0) ? PTR_LAST : back_ff - PTR_W'(1);
   assign back_inc  = (back_ff == PTR_LAST) ? '0 : back_ff + PTR_W'(1);
   assign full      = (count_ff == CNT_FULL);
   assign empty     = (count_ff == '0);
   assign go_low    = (req_ff.operation == OP_INSERT_FRONT) ^ rev_ff;

   always_comb begin
      front_in = front_ff;
      back_in  = back_ff;
      count_in = count_ff;
      rev_in   = rev_ff;
      ok_in    = ok_ff;
      take_in  = take_ff;
      wr_en    = 1'b0;
      rd_en    = 1'b0;
      wr_addr  = back_ff;
      rd_addr  = front_ff;
      if (cmd.exec) begin
         ok_in   = 1'b1;
         take_in = 1'b0;
         unique case (req_ff.operation)
            OP_INSERT_FRONT, OP_INSERT_BACK: begin
               if (full) begin
                  ok_in = 1'b0;
               end else begin
                  wr_en    = 1'b1;
                  count_in = count_ff + CNT_W'(1);
                  if (go_low) begin
                     wr_addr  = front_dec;
                     front_in = front_dec;
                  end else begin
                     wr_addr = back_ff;
                     back_in = back_inc;
                  end
               end
            end
            OP_REMOVE_FRONT: begin
               if (empty) begin
                  ok_in = 1'b0;
               end else begin
                  rd_en    = 1'b1;
                  take_in  = 1'b1;
                  count_in = count_ff - CNT_W'(1);
                  if (rev_ff) begin
                     rd_addr = back_dec;
                     back_in = back_dec;
                  end else begin
                     rd_addr  = front_ff;
                     front_in = front_inc;
                  end
               end
            end
            OP_REVERSE: begin
               if (count_ff > CNT_W'(1)) rev_in = ~rev_ff;
            end
            default: ok_in = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         back_ff  <= '0;
         count_ff <= '0;
         rev_ff   <= 1'b0;
      end else begin
         front_ff <= front_in;
         back_ff  <= back_in;
         count_ff <= count_in;
         rev_ff   <= rev_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) req_ff <= req_payload;
      ok_ff   <= ok_in;
      take_ff <= take_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= req_ff.value;
      if (rd_en) rd_ff <= mem[rd_addr];
   end

   assign count_ext = {{COUNT_FIELD_W{1'b0}}, count_ff};

   assign rsp_payload.ok            = ok_ff;
   assign rsp_payload.removed_value = take_ff ? rd_ff : 32'sd0;
   assign rsp_payload.count         = count_ext[COUNT_FIELD_W-1:0];

endmodule

// ===== sv/reversible_deque_queue_unit.sv =====
// Reversible bounded queue of signed 32-bit words held in a ring memory of DEPTH
// entries. Each request (insert front, insert back, remove front, reverse) is
// accepted when start is high and busy is low, and passes through an accept step,
// an execute step in which the controller has the datapath update the pointers,
// the count and the direction flag and access the ring memory port, and a result
// step in which the result is shown for a single cycle with rsp_valid high. busy
// is high from the cycle after acceptance to the end of that result step, so no
// new request is accepted before the result of the last one has been shown. The
// receiver cannot stall: every result must be taken in the cycle that rsp_valid
// marks. The count field carries the entry count modulo 32.
// top level; depends on rdq_pkg, rdq_controller and rdq_datapath
module reversible_deque_queue_unit #(
   parameter int DEPTH = rdq_pkg::DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  rdq_pkg::req_type req_payload,
   output logic             rsp_valid,
   output rdq_pkg::rsp_type rsp_payload
);
   import rdq_pkg::*;

   cmd_type cmd;

   rdq_controller u_controller (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   rdq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload)
   );

   assign rsp_valid = cmd.respond;

`ifndef SYNTHESIS
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_valid)
      else $error("no result two cycles after transfer");

   a_no_accept_while_responding: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result shown while idle");

   a_removed_only_on_success: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_payload.removed_value != 32'sd0)) |-> rsp_payload.ok)
      else $error("removed value on failed request");
`endif

endmodule

// ===== bench/testbench.sv =====
// self-checking bench for reversible_deque_queue_unit: directed and random requests
// against a shadow deque kept in a small scoreboard class
// depends on rdq_pkg and the reversible_deque_queue_unit rtl
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import rdq_pkg::*;

   localparam int DEPTH = DEPTH_DEFAULT;
   localparam int RANDOM_ITEMS = 2000;
   localparam int QUIET_ITEMS = 300;

   class deque_shadow;
      logic signed [31:0] ring [DEPTH];
      int                 front_idx;
      int                 back_idx;
      int                 held;
      bit                 reversed;
      rsp_type            expected_rsp [$];
      int                 mismatches;

      function new();
         front_idx = 0;
         back_idx = 0;
         held = 0;
         reversed = 1'b0;
         mismatches = 0;
      endfunction

      function void apply_request(req_type item);
         rsp_type expd;
         bit      low;
         expd.ok = 1'b1;
         expd.removed_value = '0;
         case (item.operation)
            OP_INSERT_FRONT, OP_INSERT_BACK: begin
               if (held >= DEPTH) begin
                  expd.ok = 1'b0;
               end else begin
                  low = (item.operation == OP_INSERT_FRONT) != reversed;
                  if (low) begin
                     front_idx = (front_idx + DEPTH - 1) % DEPTH;
                     ring[front_idx] = item.value;
                  end else begin
                     ring[back_idx] = item.value;
                     back_idx = (back_idx + 1) % DEPTH;
                  end
                  held++;
               end
            end
            OP_REMOVE_FRONT: begin
               if (held == 0) begin
                  expd.ok = 1'b0;
               end else if (reversed) begin
                  back_idx = (back_idx + DEPTH - 1) % DEPTH;
                  expd.removed_value = ring[back_idx];
                  held--;
               end else begin
                  expd.removed_value = ring[front_idx];
                  front_idx = (front_idx + 1) % DEPTH;
                  held--;
               end
            end
            default: begin
               if (held > 1) reversed = !reversed;
            end
         endcase
         expd.count = held[COUNT_FIELD_W-1:0];
         expected_rsp.push_back(expd);
      endfunction

      function void check_response(rsp_type got);
         rsp_type expd;
         if (expected_rsp.size() == 0) begin
            $display("%0t: unexpected response ok=%0b removed_value=%0d count=%0d",
                     $time, got.ok, got.removed_value, got.count);
            mismatches++;
            return;
         end
         expd = expected_rsp.pop_front();
         if (got.ok !== expd.ok) begin
            $display("%0t: ok expected %0b got %0b", $time, expd.ok, got.ok);
            mismatches++;
         end
         if (got.removed_value !== expd.removed_value) begin
            $display("%0t: removed_value expected %0d got %0d",
                     $time, expd.removed_value, got.removed_value);
            mismatches++;
         end
         if (got.count !== expd.count) begin
            $display("%0t: count expected %0d got %0d", $time, expd.count, got.count);
            mismatches++;
         end
      endfunction

      function int pending();
         return expected_rsp.size();
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_payload;
   logic    rsp_valid;
   rsp_type rsp_payload;

   deque_shadow shadow = new();

   reversible_deque_queue_unit #(
      .DEPTH(DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_payload(rsp_payload)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) shadow.check_response(rsp_payload);
   end

   // hold start until the transfer is taken, then note it
   task automatic send_request(op_type op, logic signed [31:0] word);
      req_type item;
      item.operation = op;
      item.value = word;
      @(negedge clock);
      start <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (busy);
      shadow.apply_request(item);
   endtask

   task automatic pause(int cycles);
      repeat (cycles) begin
         @(negedge clock);
         start <= 1'b0;
         req_payload.operation <= op_type'($urandom_range(3));
         req_payload.value <= $urandom;
      end
   endtask

   function automatic logic signed [31:0] pick_word();
      int r;
      r = $urandom_range(19);
      case (r)
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         2: return '0;
         3: return -1;
         default: return $urandom;
      endcase
   endfunction

   // fill_bias is the share of inserts out of the non-reverse requests, in percent
   function automatic op_type pick_op(int fill_bias);
      int r;
      r = $urandom_range(99);
      if (r < 15) return OP_REVERSE;
      if ($urandom_range(99) < fill_bias)
         return $urandom_range(1) ? OP_INSERT_FRONT : OP_INSERT_BACK;
      return OP_REMOVE_FRONT;
   endfunction

   initial begin
      #2_000_000;
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      int fill_bias;
      int idle_chance;
      reset = 1'b1;
      start = 1'b0;
      req_payload = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty queue, single entry and reversal corner cases
      send_request(OP_REMOVE_FRONT, 32'sh7fff_ffff);
      send_request(OP_REVERSE, -1);
      send_request(OP_INSERT_FRONT, 32'sh8000_0000);
      send_request(OP_REVERSE, '0);
      send_request(OP_INSERT_BACK, 32'sh7fff_ffff);
      send_request(OP_REVERSE, '0);
      send_request(OP_REMOVE_FRONT, '0);
      send_request(OP_REMOVE_FRONT, '0);
      send_request(OP_REMOVE_FRONT, '0);
      // fill to the top, then insert when full, reverse when full, remove
      for (int i = 0; i < DEPTH; i++)
         send_request(i[0] ? OP_INSERT_BACK : OP_INSERT_FRONT,
                      i[1] ? -1 - i : 32'sh8000_0000 + i);
      send_request(OP_INSERT_BACK, -1);
      send_request(OP_REVERSE, '0);
      send_request(OP_REMOVE_FRONT, '0);

      fill_bias = 50;
      idle_chance = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 40 == 0) begin
            case ($urandom_range(2))
               0: fill_bias = 80;
               1: fill_bias = 20;
               default: fill_bias = 50;
            endcase
            case ($urandom_range(2))
               0: idle_chance = 0;
               1: idle_chance = 20;
               default: idle_chance = 50;
            endcase
         end
         if (n < RANDOM_ITEMS - QUIET_ITEMS && $urandom_range(99) < idle_chance)
            pause($urandom_range(1, 12));
         send_request(pick_op(fill_bias), pick_word());
      end

      @(negedge clock);
      start <= 1'b0;
      while (shadow.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (shadow.mismatches == 0 && shadow.pending() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
